@@ rtl/core/handle_table_allocator_unit_macros.svh @@
// Assertion macros for the handle table allocator.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef HANDLE_TABLE_ALLOCATOR_UNIT_MACROS_SVH
`define HANDLE_TABLE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HTAB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HTAB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/htab_pkg.sv @@
// Shared constants, codes and control/status structs of the handle table.
// No dependencies.
package htab_pkg;

	localparam int TABLE_SIZE = 4096;
	localparam int TYPE_WIDTH = 4;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int ACT_W      = 2;
	localparam int HIN_W      = 16;
	localparam int TIN_W      = 4;
	localparam int DATA_W     = 64;
	localparam int HOUT_W     = 12;
	localparam int ST_W       = 2;
	localparam int FLAG_W     = TYPE_WIDTH + 1;
	localparam int ENTRY_W    = FLAG_W + DATA_W;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t ONE_IDX  = idx_t'(1);
	localparam idx_t LAST_IDX = idx_t'(TABLE_SIZE - 1);
	localparam idx_t LAST_M1  = idx_t'(TABLE_SIZE - 2);

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2,
		ST_BAD     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RES_BAD,
		RES_INVALID,
		RES_FULL,
		RES_ALLOC,
		RES_LOOK
	} res_sel_t;

	typedef struct packed {
		logic     clr_wr;
		logic     capture;
		logic     rd_handle;
		logic     scan_init;
		logic     scan_step;
		logic     alloc_wr;
		logic     free_wr;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} htab_cmd_t;

	typedef struct packed {
		logic             clr_last;
		logic [ACT_W-1:0] act;
		logic             alloc_bad;
		logic             handle_oor;
		logic             look_valid;
		logic             hit;
		logic             scan_end;
		logic             out_busy;
	} htab_sts_t;

	// Keep only the type bits the table stores.
	function automatic logic [TYPE_WIDTH-1:0] mask_type(input logic [TIN_W-1:0] b);
		logic [TYPE_WIDTH+TIN_W-1:0] ext;
		ext = {{TYPE_WIDTH{1'b0}}, b};
		return ext[TYPE_WIDTH-1:0];
	endfunction

endpackage

@@ rtl/core/htab_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module htab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/htab_ctrl.sv @@
// Sequencer of the handle table: clearing pass, decode, lookup, scan, reply.
// Depends on htab_pkg.
module htab_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  htab_pkg::htab_sts_t sts,
	output htab_pkg::htab_cmd_t cmd
);
	import htab_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_LOOK,
		S_SCAN,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.res_sel = RES_BAD;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (sts.act == ACT_ALLOC) begin
					if (sts.alloc_bad) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_BAD;
						state_d      = S_RESP;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end else if (sts.act == ACT_FREE || sts.act == ACT_QUERY) begin
					if (sts.handle_oor) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_INVALID;
						state_d      = S_RESP;
					end else begin
						cmd.rd_handle = 1'b1;
						state_d       = S_LOOK;
					end
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_BAD;
					state_d      = S_RESP;
				end
			end
			S_LOOK: begin
				cmd.free_wr  = (sts.act == ACT_FREE) && sts.look_valid;
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_LOOK;
				state_d      = S_RESP;
			end
			S_SCAN: begin
				priority if (sts.hit) begin
					cmd.alloc_wr = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ALLOC;
					state_d      = S_RESP;
				end else if (sts.scan_end) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_FULL;
					state_d      = S_RESP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/htab_dp.sv @@
// Datapath of the handle table: request registers, cursor, scan counters,
// table RAM and the reply register. Depends on htab_pkg and htab_ram.
module htab_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  htab_pkg::htab_cmd_t         cmd,
	output htab_pkg::htab_sts_t         sts,
	input  logic [htab_pkg::ACT_W-1:0]  action,
	input  logic [htab_pkg::HIN_W-1:0]  handle,
	input  logic [htab_pkg::TIN_W-1:0]  type_bits,
	input  logic [htab_pkg::DATA_W-1:0] user_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [htab_pkg::HOUT_W-1:0] handle_out,
	output logic [htab_pkg::DATA_W-1:0] data_out,
	output logic [htab_pkg::ST_W-1:0]   status
);
	import htab_pkg::*;

	// captured request
	logic [ACT_W-1:0]      act_q;
	logic [HIN_W-1:0]      handle_q;
	logic [TYPE_WIDTH-1:0] type_q;
	logic [DATA_W-1:0]     word_q;

	// sequencing state
	idx_t clr_q;
	idx_t cursor_q;
	idx_t scan_addr_q;
	idx_t chk_addr_q;
	idx_t iss_q;
	logic chk_vld_q;

	// result and reply registers
	logic [HOUT_W-1:0] res_handle_q;
	logic [DATA_W-1:0] res_data_q;
	status_t           res_status_q;
	logic              rsp_valid_q;
	logic [HOUT_W-1:0] rsp_handle_q;
	logic [DATA_W-1:0] rsp_data_q;
	status_t           rsp_status_q;

	// RAM ports
	logic               ram_we;
	idx_t               ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	idx_t               ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	idx_t                  h_idx;
	idx_t                  start_idx;
	idx_t                  next_cursor;
	logic [FLAG_W-1:0]     rd_flags;
	logic [DATA_W-1:0]     rd_word;
	logic                  rd_valid;
	logic [TYPE_WIDTH-1:0] rd_type;

	logic [HOUT_W-1:0] res_handle_d;
	logic [DATA_W-1:0] res_data_d;
	status_t           res_status_d;

	assign h_idx    = handle_q[IDX_W-1:0];
	assign rd_flags = ram_rdata[ENTRY_W-1:DATA_W];
	assign rd_word  = ram_rdata[DATA_W-1:0];
	assign rd_valid = rd_flags[TYPE_WIDTH];
	assign rd_type  = rd_flags[TYPE_WIDTH-1:0];

	assign start_idx   = (cursor_q >= LAST_IDX || cursor_q == '0) ? ONE_IDX : cursor_q;
	assign next_cursor = (chk_addr_q >= LAST_M1) ? ONE_IDX : chk_addr_q + ONE_IDX;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= action;
			handle_q <= handle;
			type_q   <= mask_type(type_bits);
			word_q   <= user_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cursor_q    <= ONE_IDX;
			scan_addr_q <= ONE_IDX;
			chk_addr_q  <= ONE_IDX;
			iss_q       <= '0;
			chk_vld_q   <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + ONE_IDX;
			end
			if (cmd.scan_init) begin
				scan_addr_q <= start_idx;
				iss_q       <= '0;
				chk_vld_q   <= 1'b0;
			end else if (cmd.scan_step) begin
				// wrap past the top back to entry 1; entry 0 is never searched
				scan_addr_q <= (scan_addr_q == LAST_IDX) ? ONE_IDX : scan_addr_q + ONE_IDX;
				iss_q       <= iss_q + ONE_IDX;
				chk_addr_q  <= scan_addr_q;
				chk_vld_q   <= 1'b1;
			end
			if (cmd.alloc_wr) begin
				cursor_q <= next_cursor;
			end
		end
	end

	// single write port: clearing pass, allocate, free
	always_comb begin
		ram_we    = cmd.clr_wr | cmd.alloc_wr | cmd.free_wr;
		ram_waddr = clr_q;
		ram_wdata = '0;
		priority if (cmd.alloc_wr) begin
			ram_waddr = chk_addr_q;
			ram_wdata = {1'b1, type_q, word_q};
		end else if (cmd.free_wr) begin
			ram_waddr = h_idx;
		end else begin
			ram_waddr = clr_q;
		end
	end

	assign ram_raddr = cmd.rd_handle ? h_idx : scan_addr_q;

	htab_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		res_handle_d = '0;
		res_data_d   = '0;
		res_status_d = ST_OK;
		unique case (cmd.res_sel)
			RES_BAD:     res_status_d = ST_BAD;
			RES_INVALID: res_status_d = ST_INVALID;
			RES_FULL:    res_status_d = ST_FULL;
			RES_ALLOC:   res_handle_d = HOUT_W'(chk_addr_q);
			RES_LOOK: begin
				priority if (!rd_valid) begin
					res_status_d = ST_INVALID;
				end else if (act_q == ACT_FREE) begin
					res_status_d = ST_OK;
				end else if (type_q == '0) begin
					res_status_d = ST_BAD;
				end else if ((rd_type & type_q) != '0) begin
					res_data_d = rd_word;
				end else begin
					res_status_d = ST_OK;
				end
			end
			default:     res_status_d = ST_BAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_handle_q <= res_handle_d;
			res_data_q   <= res_data_d;
			res_status_q <= res_status_d;
		end
		if (cmd.out_load) begin
			rsp_handle_q <= res_handle_q;
			rsp_data_q   <= res_data_q;
			rsp_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign handle_out = rsp_handle_q;
	assign data_out   = rsp_data_q;
	assign status     = rsp_status_q;

	assign sts.clr_last   = (clr_q == LAST_IDX);
	assign sts.act        = act_q;
	assign sts.alloc_bad  = (type_q == '0) || (word_q == '0);
	assign sts.handle_oor = (32'(handle_q) >= TABLE_SIZE);
	assign sts.look_valid = rd_valid;
	assign sts.hit        = chk_vld_q && (rd_word == '0);
	assign sts.scan_end   = (iss_q == LAST_IDX);
	assign sts.out_busy   = rsp_valid_q && rsp_stall;

endmodule

@@ rtl/core/handle_table_allocator_unit.sv @@
// Handle table allocator: top level joining sequencer and datapath.
// Depends on htab_pkg, htab_ctrl, htab_dp and the assertion macro header.
//
// Usage:
//   Request channel (req_valid/req_stall) carries one word per command:
//   action (allocate, free, query), handle, type_bits and user_data.
//   Reply channel (rsp_valid/rsp_stall) returns one word per request:
//   handle_out, data_out and status. A word moves on an edge with valid
//   high and stall low.
//   Reset starts a clearing pass over the table RAM, one entry a cycle,
//   over all TABLE_SIZE entries; req_stall stays high until it is done.
//   Free and query read the entry once: an accepted request passes decode,
//   lookup and reply; a request rejected at decode goes straight to reply.
//   Allocate scans the table RAM through its single read port, one entry
//   a cycle from the next-fit cursor, until it finds a free entry or the
//   scan ends. One request is in work at a time; req_stall drops as the
//   reply shows.
//   The reply sits in an output register; the next request is taken while
//   it waits. A stalled receiver holds the reply and, once the following
//   result is ready, holds the block until the reply register frees.
`include "handle_table_allocator_unit_macros.svh"

module handle_table_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [htab_pkg::ACT_W-1:0]  action,
	input  logic [htab_pkg::HIN_W-1:0]  handle,
	input  logic [htab_pkg::TIN_W-1:0]  type_bits,
	input  logic [htab_pkg::DATA_W-1:0] user_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [htab_pkg::HOUT_W-1:0] handle_out,
	output logic [htab_pkg::DATA_W-1:0] data_out,
	output logic [htab_pkg::ST_W-1:0]   status
);
	import htab_pkg::*;

	htab_cmd_t cmd;
	htab_sts_t sts;

	// sequencer: owns the request handshake and issues datapath commands
	htab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: table RAM, cursor, scan counters, reply register
	htab_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.action    (action),
		.handle    (handle),
		.type_bits (type_bits),
		.user_data (user_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.handle_out(handle_out),
		.data_out  (data_out),
		.status    (status)
	);

	// a taken request blocks the next one in the following cycle
	`HTAB_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request taken while busy")
	// the RAM write port has one user at a time
	`HTAB_ASSERT_NOW(a_one_writer, 1'b1, $onehot0({cmd.clr_wr, cmd.alloc_wr, cmd.free_wr}), "RAM write conflict")
	// no request is taken during the clearing pass
	`HTAB_ASSERT_NOW(a_stall_in_clear, cmd.clr_wr, req_stall, "request taken during clear")
	// a loaded reply shows up on the port
	`HTAB_ASSERT_NEXT(a_reply_after_load, cmd.out_load, rsp_valid, "reply load lost")

endmodule
